[rtl/core/hbc_pkg.sv]
package hbc_pkg;

   // Fixed field widths of the pixel and result streams.
   localparam int unsigned CHAN_BITS      = 8;
   localparam int unsigned LIMIT_BITS     = 9;
   localparam int unsigned HUE_BITS       = 8;
   localparam int unsigned OUT_COUNT_BITS = 20;
   localparam int unsigned CODE_BITS      = 2;
   localparam int unsigned CSR_INDEX_BITS = 3;
   localparam int unsigned CSR_DATA_BITS  = 9;
   localparam int unsigned REQ_DATA_BITS  = 24;
   localparam int unsigned RSP_DATA_BITS  = 64;

   // Default tally width.
   localparam int unsigned COUNT_BITS_DEFAULT = 20;

   // Entries in the queue between the classifier and the tally engine.
   localparam int unsigned QUEUE_DEPTH = 2;

   // Register indexes on the csr port.
   localparam logic [CSR_INDEX_BITS-1:0] REG_BG_BLUE      = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_BG_GREEN     = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_BG_RED       = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_DIST_LIMIT   = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_GREEN_START  = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] REG_PURPLE_START = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] REG_PURPLE_END   = 3'd6;

   // Register reset values.
   localparam logic [LIMIT_BITS-1:0] DIST_LIMIT_RESET   = 9'd50;
   localparam logic [HUE_BITS-1:0]   GREEN_START_RESET  = 8'd30;
   localparam logic [HUE_BITS-1:0]   PURPLE_START_RESET = 8'd90;
   localparam logic [HUE_BITS-1:0]   PURPLE_END_RESET   = 8'd150;

   // Hue wraps at half a turn in 8-bit hue units.
   localparam logic [HUE_BITS-1:0] HUE_WRAP = 8'd180;

   // Winning color codes.
   localparam logic [CODE_BITS-1:0] COLOR_RED    = 2'd0;
   localparam logic [CODE_BITS-1:0] COLOR_GREEN  = 2'd1;
   localparam logic [CODE_BITS-1:0] COLOR_PURPLE = 2'd2;

   typedef enum logic [1:0] {
      BAND_NONE,
      BAND_RED,
      BAND_GREEN,
      BAND_PURPLE
   } band_type;

   typedef struct packed {
      band_type band;
      logic     last;
   } entry_type;

   typedef struct packed {
      logic [CHAN_BITS-1:0]  bg_blue;
      logic [CHAN_BITS-1:0]  bg_green;
      logic [CHAN_BITS-1:0]  bg_red;
      logic [LIMIT_BITS-1:0] dist_limit;
      logic [HUE_BITS-1:0]   green_start;
      logic [HUE_BITS-1:0]   purple_start;
      logic [HUE_BITS-1:0]   purple_end;
   } cfg_type;

endpackage

[rtl/core/hue_band_color_classifier.sv]
// Channel  Direction  Transfer when        Contents
// req      in         req_tvalid&tready    tdata blue/green/red, tuser mask, tlast
// rsp      out        rsp_tvalid&tready    tdata code/red/green/purple counts
// csr      in         csr_we               csr_index selects, csr_wdata value
//
// A pixel that reaches the hue divider runs the 8-step divider, one quotient bit per
// cycle for the hue; a masked-out, background or grey pixel skips the divider.
// The next pixel is taken only once the last one has gone to the queue.
// Reset is synchronous and active high; it clears the tallies, the queue, the
// result register and the configuration to its defaults.
// The two entry queue lets the classifier finish a pixel while a result waits;
// only a last pixel waits on a free result register.
module hue_band_color_classifier
   import hbc_pkg::*;
#(
   parameter int unsigned COUNT_BITS = COUNT_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // pixel_blue [7:0], pixel_green [15:8], pixel_red [23:16]
   input  logic [REQ_DATA_BITS-1:0]  req_tdata,
   // in_mask [0]
   input  logic [0:0]                req_tuser,
   input  logic                      req_tlast,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // color_code [1:0], red_count [21:2], green_count [41:22],
   // purple_count [61:42], zero fill [63:62]
   output logic [RSP_DATA_BITS-1:0]  rsp_tdata,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   cfg_type                   cfg_ff, cfg_in;
   logic                      push_valid, queue_full, queue_empty, pop;
   entry_type                 push_entry, head;
   logic [CODE_BITS-1:0]      out_code;
   logic [OUT_COUNT_BITS-1:0] out_red, out_green, out_purple;

   // Configuration registers. Writes to an index past the list are dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_BG_BLUE:      cfg_in.bg_blue      = csr_wdata[CHAN_BITS-1:0];
            REG_BG_GREEN:     cfg_in.bg_green     = csr_wdata[CHAN_BITS-1:0];
            REG_BG_RED:       cfg_in.bg_red       = csr_wdata[CHAN_BITS-1:0];
            REG_DIST_LIMIT:   cfg_in.dist_limit   = csr_wdata[LIMIT_BITS-1:0];
            REG_GREEN_START:  cfg_in.green_start  = csr_wdata[HUE_BITS-1:0];
            REG_PURPLE_START: cfg_in.purple_start = csr_wdata[HUE_BITS-1:0];
            REG_PURPLE_END:   cfg_in.purple_end   = csr_wdata[HUE_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bg_blue      <= '0;
         cfg_ff.bg_green     <= '0;
         cfg_ff.bg_red       <= '0;
         cfg_ff.dist_limit   <= DIST_LIMIT_RESET;
         cfg_ff.green_start  <= GREEN_START_RESET;
         cfg_ff.purple_start <= PURPLE_START_RESET;
         cfg_ff.purple_end   <= PURPLE_END_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front: captures the pixel, runs the background test and the hue divider,
   // and hands a band decision to the queue.
   hbc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .pix_valid  (req_tvalid),
      .pix_ready  (req_tready),
      .pix_blue   (req_tdata[7:0]),
      .pix_green  (req_tdata[15:8]),
      .pix_red    (req_tdata[23:16]),
      .pix_mask   (req_tuser[0]),
      .pix_last   (req_tlast),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .queue_full (queue_full)
   );

   hbc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push_valid),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .empty      (queue_empty),
      .head       (head)
   );

   // Back: updates the saturating tallies and, on the last pixel, loads the
   // result register with the winner and clears the tallies.
   hbc_back #(
      .COUNT_BITS (COUNT_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .empty      (queue_empty),
      .head       (head),
      .pop        (pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_code   (out_code),
      .out_red    (out_red),
      .out_green  (out_green),
      .out_purple (out_purple)
   );

   assign rsp_tdata = {2'b00, out_purple, out_green, out_red, out_code};

endmodule

[rtl/core/hbc_front.sv]
module hbc_front
   import hbc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  cfg_type              cfg,
   input  logic                 pix_valid,
   output logic                 pix_ready,
   input  logic [CHAN_BITS-1:0] pix_blue,
   input  logic [CHAN_BITS-1:0] pix_green,
   input  logic [CHAN_BITS-1:0] pix_red,
   input  logic                 pix_mask,
   input  logic                 pix_last,
   output logic                 push_valid,
   output entry_type            push_entry,
   input  logic                 queue_full
);

   localparam int unsigned NUM_BITS = 11;
   localparam int unsigned SQ_BITS  = 2 * CHAN_BITS;
   localparam int unsigned D2_BITS  = 2 * LIMIT_BITS;
   localparam int unsigned DIV_BITS = 17;
   localparam int unsigned CNT_BITS = $clog2(HUE_BITS);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CALC,
      ST_PREP,
      ST_DIV,
      ST_PUSH
   } state_type;

   state_type             state_ff, state_in;
   logic [CHAN_BITS-1:0]  b_ff, g_ff, r_ff, b_in, g_in, r_in;
   logic                  mask_ff, last_ff, mask_in, last_in;
   logic [SQ_BITS-1:0]    sqb_ff, sqg_ff, sqr_ff, sqb_in, sqg_in, sqr_in;
   logic [D2_BITS-1:0]    lim2_ff, lim2_in;
   logic [NUM_BITS-1:0]   num_ff, num_in;
   logic [CHAN_BITS-1:0]  d_ff, d_in;
   logic [DIV_BITS-1:0]   rem_ff, rem_in, dsh_ff, dsh_in;
   logic [HUE_BITS-1:0]   q_ff, q_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic                  counted_ff, counted_in;

   logic [CHAN_BITS-1:0]  vmax, vmin, dif;
   logic [CHAN_BITS-1:0]  adb, adg, adr;
   logic [NUM_BITS-1:0]   nb, ng, nr, nd;
   logic [D2_BITS-1:0]    d2;
   logic [HUE_BITS-1:0]   hue;
   band_type              band;

   // Channel extremes and hue numerator, from the captured pixel.
   always_comb begin
      vmax = r_ff;
      vmin = r_ff;
      if (g_ff > vmax) vmax = g_ff;
      if (b_ff > vmax) vmax = b_ff;
      if (g_ff < vmin) vmin = g_ff;
      if (b_ff < vmin) vmin = b_ff;
      dif = vmax - vmin;
      nb  = NUM_BITS'(b_ff);
      ng  = NUM_BITS'(g_ff);
      nr  = NUM_BITS'(r_ff);
      nd  = NUM_BITS'(dif);
      // The sums below are taken modulo 2^11; each true value is in 0..1530.
      if (vmax == r_ff) begin
         if (g_ff >= b_ff) num_in = ng - nb;
         else              num_in = ng - nb + NUM_BITS'(nd * NUM_BITS'(6));
      end else if (vmax == g_ff) begin
         num_in = nb - nr + (nd << 1);
      end else begin
         num_in = nr - ng + (nd << 2);
      end
      d_in = dif;
      adb = (b_ff >= cfg.bg_blue)  ? b_ff - cfg.bg_blue  : cfg.bg_blue - b_ff;
      adg = (g_ff >= cfg.bg_green) ? g_ff - cfg.bg_green : cfg.bg_green - g_ff;
      adr = (r_ff >= cfg.bg_red)   ? r_ff - cfg.bg_red   : cfg.bg_red - r_ff;
      sqb_in  = SQ_BITS'(adb) * SQ_BITS'(adb);
      sqg_in  = SQ_BITS'(adg) * SQ_BITS'(adg);
      sqr_in  = SQ_BITS'(adr) * SQ_BITS'(adr);
      lim2_in = D2_BITS'(cfg.dist_limit) * D2_BITS'(cfg.dist_limit);
   end

   assign d2 = D2_BITS'(sqb_ff) + D2_BITS'(sqg_ff) + D2_BITS'(sqr_ff);

   // Hue and band from the finished quotient.
   always_comb begin
      hue = (q_ff >= HUE_WRAP) ? q_ff - HUE_WRAP : q_ff;
      if (!counted_ff || hue == '0)
         band = BAND_NONE;
      else if (hue < cfg.green_start || hue > cfg.purple_end)
         band = BAND_RED;
      else if (hue < cfg.purple_start)
         band = BAND_GREEN;
      else
         band = BAND_PURPLE;
   end

   always_comb begin
      state_in   = state_ff;
      b_in       = b_ff;
      g_in       = g_ff;
      r_in       = r_ff;
      mask_in    = mask_ff;
      last_in    = last_ff;
      rem_in     = rem_ff;
      dsh_in     = dsh_ff;
      q_in       = q_ff;
      cnt_in     = cnt_ff;
      counted_in = counted_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (pix_valid) begin
               b_in     = pix_blue;
               g_in     = pix_green;
               r_in     = pix_red;
               mask_in  = pix_mask;
               last_in  = pix_last;
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            state_in = ST_PREP;
         end
         ST_PREP: begin
            counted_in = mask_ff && (d2 >= lim2_ff) && (d_ff != '0);
            rem_in     = DIV_BITS'(num_ff) * DIV_BITS'(60) + DIV_BITS'(d_ff);
            dsh_in     = DIV_BITS'(d_ff) << (HUE_BITS);
            q_in       = '0;
            cnt_in     = '0;
            state_in   = counted_in ? ST_DIV : ST_PUSH;
         end
         ST_DIV: begin
            // One quotient bit per cycle, most significant first.
            if (rem_ff >= dsh_ff) begin
               rem_in = rem_ff - dsh_ff;
               q_in   = {q_ff[HUE_BITS-2:0], 1'b1};
            end else begin
               q_in   = {q_ff[HUE_BITS-2:0], 1'b0};
            end
            dsh_in = dsh_ff >> 1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_BITS'(HUE_BITS - 1))
               state_in = ST_PUSH;
         end
         ST_PUSH: begin
            if (!queue_full)
               state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      b_ff       <= b_in;
      g_ff       <= g_in;
      r_ff       <= r_in;
      mask_ff    <= mask_in;
      last_ff    <= last_in;
      sqb_ff     <= sqb_in;
      sqg_ff     <= sqg_in;
      sqr_ff     <= sqr_in;
      lim2_ff    <= lim2_in;
      num_ff     <= num_in;
      d_ff       <= d_in;
      rem_ff     <= rem_in;
      dsh_ff     <= dsh_in;
      q_ff       <= q_in;
      cnt_ff     <= cnt_in;
      counted_ff <= counted_in;
   end

   assign pix_ready       = (state_ff == ST_IDLE);
   assign push_valid      = (state_ff == ST_PUSH);
   assign push_entry.band = band;
   assign push_entry.last = last_ff;

endmodule

[rtl/core/hbc_queue.sv]
module hbc_queue
   import hbc_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   output logic      full,
   input  logic      pop,
   output logic      empty,
   output entry_type head
);

   localparam int unsigned PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int unsigned CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   entry_type             slot_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_BITS-1:0]   fill_ff, fill_in;
   logic                  do_push, do_pop;

   assign full    = (fill_ff == CNT_BITS'(QUEUE_DEPTH));
   assign empty   = (fill_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = slot_ff[rd_ff];

   always_comb begin
      wr_in   = wr_ff;
      rd_in   = rd_ff;
      fill_in = fill_ff;
      if (do_push)
         wr_in = (wr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      if (do_pop)
         rd_in = (rd_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      if (do_push && !do_pop)
         fill_in = fill_ff + 1'b1;
      else if (do_pop && !do_push)
         fill_in = fill_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff   <= '0;
         rd_ff   <= '0;
         fill_ff <= '0;
      end else begin
         wr_ff   <= wr_in;
         rd_ff   <= rd_in;
         fill_ff <= fill_in;
      end
      if (do_push)
         slot_ff[wr_ff] <= push_entry;
   end

endmodule

[rtl/core/hbc_back.sv]
module hbc_back
   import hbc_pkg::*;
#(
   parameter int unsigned COUNT_BITS = COUNT_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      empty,
   input  entry_type                 head,
   output logic                      pop,
   output logic                      out_valid,
   input  logic                      out_ready,
   output logic [CODE_BITS-1:0]      out_code,
   output logic [OUT_COUNT_BITS-1:0] out_red,
   output logic [OUT_COUNT_BITS-1:0] out_green,
   output logic [OUT_COUNT_BITS-1:0] out_purple
);

   localparam logic [COUNT_BITS-1:0] TALLY_MAX = '1;

   logic [COUNT_BITS-1:0]     red_ff, green_ff, purple_ff;
   logic [COUNT_BITS-1:0]     red_in, green_in, purple_in;
   logic [COUNT_BITS-1:0]     red_nx, green_nx, purple_nx;
   logic                      valid_ff, valid_in;
   logic [CODE_BITS-1:0]      code_ff, code_in, winner;
   logic [OUT_COUNT_BITS-1:0] ored_ff, ogreen_ff, opurple_ff;
   logic [OUT_COUNT_BITS-1:0] ored_in, ogreen_in, opurple_in;

   // A last entry needs a free result register; others always drain.
   assign pop = !empty && (!head.last || !valid_ff || out_ready);

   always_comb begin
      red_nx    = red_ff;
      green_nx  = green_ff;
      purple_nx = purple_ff;
      case (head.band)
         BAND_RED:    if (red_ff != TALLY_MAX)    red_nx    = red_ff + 1'b1;
         BAND_GREEN:  if (green_ff != TALLY_MAX)  green_nx  = green_ff + 1'b1;
         BAND_PURPLE: if (purple_ff != TALLY_MAX) purple_nx = purple_ff + 1'b1;
         default: ;
      endcase
      if (red_nx > green_nx)
         winner = (red_nx > purple_nx) ? COLOR_RED : COLOR_PURPLE;
      else
         winner = (green_nx > purple_nx) ? COLOR_GREEN : COLOR_PURPLE;
   end

   always_comb begin
      red_in     = red_ff;
      green_in   = green_ff;
      purple_in  = purple_ff;
      valid_in   = valid_ff && !out_ready;
      code_in    = code_ff;
      ored_in    = ored_ff;
      ogreen_in  = ogreen_ff;
      opurple_in = opurple_ff;
      if (pop) begin
         if (head.last) begin
            valid_in   = 1'b1;
            code_in    = winner;
            ored_in    = OUT_COUNT_BITS'(red_nx);
            ogreen_in  = OUT_COUNT_BITS'(green_nx);
            opurple_in = OUT_COUNT_BITS'(purple_nx);
            red_in     = '0;
            green_in   = '0;
            purple_in  = '0;
         end else begin
            red_in    = red_nx;
            green_in  = green_nx;
            purple_in = purple_nx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         red_ff    <= '0;
         green_ff  <= '0;
         purple_ff <= '0;
         valid_ff  <= 1'b0;
      end else begin
         red_ff    <= red_in;
         green_ff  <= green_in;
         purple_ff <= purple_in;
         valid_ff  <= valid_in;
      end
      code_ff    <= code_in;
      ored_ff    <= ored_in;
      ogreen_ff  <= ogreen_in;
      opurple_ff <= opurple_in;
   end

   assign out_valid  = valid_ff;
   assign out_code   = code_ff;
   assign out_red    = ored_ff;
   assign out_green  = ogreen_ff;
   assign out_purple = opurple_ff;

endmodule

[rtl/core/hbc_checker.sv]
module hbc_checker
   import hbc_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_tvalid,
   input logic                      rsp_tready,
   input logic [RSP_DATA_BITS-1:0]  rsp_tdata
);

   logic [CODE_BITS-1:0]      code;
   logic [OUT_COUNT_BITS-1:0] cnt_r, cnt_g, cnt_p;

   assign code  = rsp_tdata[1:0];
   assign cnt_r = rsp_tdata[21:2];
   assign cnt_g = rsp_tdata[41:22];
   assign cnt_p = rsp_tdata[61:42];

   // A stalled result stays offered.
   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result withdrawn while stalled");

   // A stalled result keeps its payload.
   a_hold_data: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("result changed while stalled");

   // No result appears in the cycle after reset.
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result offered right after reset");

   // The code names only red, green or purple.
   a_code_known: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (code == COLOR_RED || code == COLOR_GREEN || code == COLOR_PURPLE))
      else $error("unknown color code");

   // Red wins exactly when its count beats both others.
   a_red_winner: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((code == COLOR_RED) == (cnt_r > cnt_g && cnt_r > cnt_p)))
      else $error("red winner disagrees with the counts");

endmodule

bind hue_band_color_classifier hbc_checker u_hbc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

[dv/tb_hue_band_color_classifier.sv]
`timescale 1ns / 100ps

// Self-checking bench for the hue band color classifier.
// Pixels are queued by the stimulus process and offered by a clocked driver.
// Each pixel transfer is run through a local model of the classifier, and that
// model queues the card result a last pixel is due to produce. A clocked monitor
// compares every result transfer with the oldest queued card result.
module tb_hue_band_color_classifier;
   import hbc_pkg::*;

   // The tally width is left at the block's default.
   localparam int unsigned TALLY_BITS = COUNT_BITS_DEFAULT;
   localparam longint unsigned TALLY_MAX = (64'd1 << TALLY_BITS) - 1;

   // Index 7 is not a register. A write to it must leave every register unchanged.
   localparam logic [CSR_INDEX_BITS-1:0] REG_UNUSED = 3'd7;

   // The slowest pixel runs the whole hue divider. Allow for two queued entries
   // and a result register on top of that.
   localparam int SETTLE_CYCLES = 48;
   localparam int HOLD_CYCLES   = 800;
   localparam int MAX_PRINTED   = 30;

   typedef enum int {
      SET_RANDOM,
      SET_OPEN,
      SET_CLOSED,
      SET_REVERSED,
      SET_NARROW,
      SET_WHITE_CARD
   } setting_type;

   typedef enum int {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_type;

   typedef struct {
      logic [CHAN_BITS-1:0] blue;
      logic [CHAN_BITS-1:0] green;
      logic [CHAN_BITS-1:0] red;
      logic                 mask;
      logic                 last;
   } pixel_type;

   typedef struct {
      logic [CODE_BITS-1:0]      code;
      logic [OUT_COUNT_BITS-1:0] red;
      logic [OUT_COUNT_BITS-1:0] green;
      logic [OUT_COUNT_BITS-1:0] purple;
   } verdict_type;

   // Every block input starts at a known value.
   logic                      clock      = 1'b0;
   logic                      reset      = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_DATA_BITS-1:0]  req_tdata  = '0;
   logic [0:0]                req_tuser  = '0;
   logic                      req_tlast  = 1'b0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0]  rsp_tdata;
   logic                      csr_we     = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index  = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata  = '0;

   // These control knobs change only at the falling edge. The clocked driver and
   // monitor sample them at the rising edge without a race.
   int unsigned sender_idle_pct   = 0;
   int unsigned receiver_stall_pct = 0;
   bit          receiver_hold     = 1'b0;

   pixel_type   pixels_waiting[$];
   verdict_type verdicts_due[$];
   verdict_type verdict_head;

   // This is a local copy of the registers and the three band tallies.
   cfg_type         cfg;
   longint unsigned red_hits;
   longint unsigned green_hits;
   longint unsigned purple_hits;

   int error_count    = 0;
   int pixels_sent    = 0;
   int cards_checked  = 0;
   int settings_used  = 0;

   hue_band_color_classifier #(
      .COUNT_BITS(TALLY_BITS)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // This bounds the run. A correct run ends far below this time, even with every
   // pixel at its slowest and every result stalled.
   initial begin
      #2_000_000;
      $display("tb: failure");
      $finish;
   end

   // Each failure prints one line, up to a limit, and is always counted.
   task automatic flag_error(input string text);
      error_count++;
      if (error_count <= MAX_PRINTED) begin
         $display("[%0t] mismatch: %s", $realtime, text);
      end
   endtask

   task automatic check_field(input string name, input longint got, input longint want);
      if (got != want) begin
         flag_error($sformatf("%s got %0d expected %0d", name, got, want));
      end
   endtask

   // This computes the 8-bit hue (0..179) with the numerator taken from the largest
   // channel. Red is checked first when channels tie, then green. The division
   // rounds half up, and a hue of 180 folds back to 0.
   function automatic int unsigned pixel_hue(input int b, input int g, input int r);
      int          top;
      int          bottom;
      int          span;
      int          num;
      int unsigned hue;
      top = r;
      bottom = r;
      if (g > top) top = g;
      if (b > top) top = b;
      if (g < bottom) bottom = g;
      if (b < bottom) bottom = b;
      span = top - bottom;
      if (span == 0) return 0;
      if (top == r) begin
         num = g - b;
         if (num < 0) num += 6 * span;
      end else if (top == g) begin
         num = b - r + 2 * span;
      end else begin
         num = r - g + 4 * span;
      end
      hue = (60 * num + span) / (2 * span);
      if (hue >= HUE_WRAP) hue -= HUE_WRAP;
      return hue;
   endfunction

   // This handles one accepted pixel. It tallies the pixel's band, and on a last
   // pixel it queues the card result and clears the tallies.
   function automatic void classify_pixel(input logic [CHAN_BITS-1:0] b,
                                          input logic [CHAN_BITS-1:0] g,
                                          input logic [CHAN_BITS-1:0] r,
                                          input logic mask, input logic last);
      int          db;
      int          dg;
      int          dr;
      int unsigned dist_sq;
      int unsigned limit_sq;
      int unsigned hue;
      verdict_type v;
      if (mask) begin
         db = int'(b) - int'(cfg.bg_blue);
         dg = int'(g) - int'(cfg.bg_green);
         dr = int'(r) - int'(cfg.bg_red);
         dist_sq = db * db + dg * dg + dr * dr;
         limit_sq = int'(cfg.dist_limit) * int'(cfg.dist_limit);
         if (dist_sq >= limit_sq) begin
            hue = pixel_hue(int'(b), int'(g), int'(r));
            // Hue zero is never counted. Grey pixels fall here.
            if (hue != 0) begin
               if (hue < cfg.green_start || hue > cfg.purple_end) begin
                  if (red_hits < TALLY_MAX) red_hits++;
               end else if (hue < cfg.purple_start) begin
                  if (green_hits < TALLY_MAX) green_hits++;
               end else begin
                  if (purple_hits < TALLY_MAX) purple_hits++;
               end
            end
         end
      end
      if (last) begin
         // Strict greater-than: a tie with purple goes to purple, red-green to green.
         if (red_hits > green_hits) begin
            v.code = (red_hits > purple_hits) ? COLOR_RED : COLOR_PURPLE;
         end else begin
            v.code = (green_hits > purple_hits) ? COLOR_GREEN : COLOR_PURPLE;
         end
         v.red    = red_hits[OUT_COUNT_BITS-1:0];
         v.green  = green_hits[OUT_COUNT_BITS-1:0];
         v.purple = purple_hits[OUT_COUNT_BITS-1:0];
         verdicts_due.insert(verdicts_due.size(), v);
         red_hits = 0;
         green_hits = 0;
         purple_hits = 0;
      end
   endfunction

   // Driver: a transfer seen at this edge goes to the model first. When the bus slot
   // is free, the next queued pixel is offered unless the sender idles this cycle.
   // A pixel that is not accepted stays on the bus unchanged.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            classify_pixel(req_tdata[7:0], req_tdata[15:8], req_tdata[23:16],
                           req_tuser[0], req_tlast);
            pixels_sent++;
         end
         if (!req_tvalid || req_tready) begin
            if (pixels_waiting.size() != 0 &&
                $urandom_range(0, 99) >= sender_idle_pct) begin
               req_tvalid <= 1'b1;
               req_tdata  <= {pixels_waiting[0].red, pixels_waiting[0].green,
                              pixels_waiting[0].blue};
               req_tuser  <= pixels_waiting[0].mask;
               req_tlast  <= pixels_waiting[0].last;
               void'(pixels_waiting.pop_front());
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor: each result transfer is checked field by field against the oldest
   // expected card. The ready signal drops at random, and stays low for as long as
   // the stimulus process holds off the receiver.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (verdicts_due.size() == 0) begin
               flag_error($sformatf("result with nothing expected, tdata %h", rsp_tdata));
            end else begin
               verdict_head = verdicts_due.pop_front();
               check_field("color_code", rsp_tdata[1:0], verdict_head.code);
               check_field("red_count", rsp_tdata[21:2], verdict_head.red);
               check_field("green_count", rsp_tdata[41:22], verdict_head.green);
               check_field("purple_count", rsp_tdata[61:42], verdict_head.purple);
               check_field("zero fill", rsp_tdata[63:62], 0);
               cards_checked++;
            end
         end
         rsp_tready <= !receiver_hold && ($urandom_range(0, 99) >= receiver_stall_pct);
      end
   end

   function automatic void push_pixel(input logic [CHAN_BITS-1:0] b,
                                      input logic [CHAN_BITS-1:0] g,
                                      input logic [CHAN_BITS-1:0] r,
                                      input logic mask, input logic last);
      pixel_type p;
      p.blue = b;
      p.green = g;
      p.red = r;
      p.mask = mask;
      p.last = last;
      pixels_waiting.insert(pixels_waiting.size(), p);
   endfunction

   // This returns a channel value within a spread around the background, clamped to
   // the channel range.
   function automatic logic [CHAN_BITS-1:0] nudge(input logic [CHAN_BITS-1:0] center,
                                                  input int spread);
      int v;
      v = int'(center) + int'($urandom_range(0, 2 * spread)) - spread;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return v[CHAN_BITS-1:0];
   endfunction

   // Most pixels are uniform random. The rest aim at the distance threshold, near-grey
   // colors, fully saturated hues and pairs of tied channels, which are the edges of
   // the hue formula.
   function automatic void push_random_pixel(input logic last);
      logic [CHAN_BITS-1:0] b;
      logic [CHAN_BITS-1:0] g;
      logic [CHAN_BITS-1:0] r;
      int                   spread;
      b = CHAN_BITS'($urandom);
      g = CHAN_BITS'($urandom);
      r = CHAN_BITS'($urandom);
      case ($urandom_range(0, 9))
         5: begin
            spread = int'(cfg.dist_limit) / 2 + 4;
            b = nudge(cfg.bg_blue, spread);
            g = nudge(cfg.bg_green, spread);
            r = nudge(cfg.bg_red, spread);
         end
         6: begin
            g = b;
            r = $urandom_range(0, 1) ? b : b ^ 8'h01;
         end
         7: begin
            case ($urandom_range(0, 2))
               0: begin r = '1; b = '0; end
               1: begin g = '1; r = '0; end
               default: begin b = '1; g = '0; end
            endcase
         end
         8: begin
            if ($urandom_range(0, 1)) g = r;
            else b = g;
         end
         default: ;
      endcase
      push_pixel(b, g, r, $urandom_range(0, 9) != 0, last);
   endfunction

   // This queues whole cards of random length until about the requested number of
   // pixels is reached.
   function automatic void push_cards(input int pixel_goal, input int max_len);
      int left;
      int len;
      left = pixel_goal;
      while (left > 0) begin
         len = $urandom_range(1, max_len);
         for (int i = 0; i < len; i++) begin
            push_random_pixel(i == len - 1);
         end
         left -= len;
      end
   endfunction

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         REG_BG_BLUE:      cfg.bg_blue      = value[CHAN_BITS-1:0];
         REG_BG_GREEN:     cfg.bg_green     = value[CHAN_BITS-1:0];
         REG_BG_RED:       cfg.bg_red       = value[CHAN_BITS-1:0];
         REG_DIST_LIMIT:   cfg.dist_limit   = value[LIMIT_BITS-1:0];
         REG_GREEN_START:  cfg.green_start  = value[HUE_BITS-1:0];
         REG_PURPLE_START: cfg.purple_start = value[HUE_BITS-1:0];
         REG_PURPLE_END:   cfg.purple_end   = value[HUE_BITS-1:0];
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // This writes all seven registers for one setting. The open and closed limits,
   // the widest bands and a reversed band order are the extremes.
   task automatic apply_setting(input setting_type kind);
      logic [CSR_DATA_BITS-1:0] bg_b;
      logic [CSR_DATA_BITS-1:0] bg_g;
      logic [CSR_DATA_BITS-1:0] bg_r;
      logic [CSR_DATA_BITS-1:0] limit;
      logic [CSR_DATA_BITS-1:0] g_start;
      logic [CSR_DATA_BITS-1:0] p_start;
      logic [CSR_DATA_BITS-1:0] p_end;
      bg_b    = CSR_DATA_BITS'($urandom_range(0, 255));
      bg_g    = CSR_DATA_BITS'($urandom_range(0, 255));
      bg_r    = CSR_DATA_BITS'($urandom_range(0, 255));
      limit   = CSR_DATA_BITS'($urandom_range(0, 160));
      g_start = CSR_DATA_BITS'($urandom_range(1, 179));
      p_start = CSR_DATA_BITS'($urandom_range(1, 179));
      p_end   = CSR_DATA_BITS'($urandom_range(1, 179));
      case (kind)
         SET_OPEN: begin
            limit = '0;
            g_start = CSR_DATA_BITS'(1);
            p_start = CSR_DATA_BITS'(1);
            p_end = CSR_DATA_BITS'(179);
         end
         SET_CLOSED: limit = CSR_DATA_BITS'(442);
         SET_REVERSED: begin
            g_start = CSR_DATA_BITS'(179);
            p_start = CSR_DATA_BITS'(179);
            p_end = CSR_DATA_BITS'(1);
         end
         SET_NARROW: begin
            g_start = CSR_DATA_BITS'(60);
            p_start = CSR_DATA_BITS'(100);
            p_end = CSR_DATA_BITS'(140);
         end
         SET_WHITE_CARD: begin
            bg_b = CSR_DATA_BITS'(255);
            bg_g = CSR_DATA_BITS'(255);
            bg_r = CSR_DATA_BITS'(255);
            limit = CSR_DATA_BITS'(100);
            g_start = CSR_DATA_BITS'(GREEN_START_RESET);
            p_start = CSR_DATA_BITS'(PURPLE_START_RESET);
            p_end = CSR_DATA_BITS'(PURPLE_END_RESET);
         end
         default: ;
      endcase
      write_reg(REG_BG_BLUE, bg_b);
      write_reg(REG_BG_GREEN, bg_g);
      write_reg(REG_BG_RED, bg_r);
      write_reg(REG_DIST_LIMIT, limit);
      write_reg(REG_GREEN_START, g_start);
      write_reg(REG_PURPLE_START, p_start);
      write_reg(REG_PURPLE_END, p_end);
      settings_used++;
   endtask

   task automatic set_idling(input idle_type mode);
      @(negedge clock);
      sender_idle_pct    = (mode == IDLE_SENDER) ? 59 : (mode == IDLE_BOTH) ? 17 : 0;
      receiver_stall_pct = (mode == IDLE_RECEIVER) ? 59 : (mode == IDLE_BOTH) ? 17 : 0;
   endtask

   // This waits until every queued pixel has been transferred and every expected card
   // has come back. It then lets dropped pixels still inside the block finish.
   task automatic wait_drained();
      do @(negedge clock);
      while (pixels_waiting.size() != 0 || req_tvalid || verdicts_due.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // This runs one phase under one setting. With a midway pause, the sender stops
   // halfway until the block has returned every result.
   task automatic run_phase(input setting_type kind, input idle_type mode,
                            input int pixel_goal, input int max_len,
                            input bit pause_midway);
      apply_setting(kind);
      set_idling(mode);
      if (pause_midway) begin
         push_cards(pixel_goal / 2, max_len);
         wait_drained();
         push_cards(pixel_goal - pixel_goal / 2, max_len);
      end else begin
         push_cards(pixel_goal, max_len);
      end
      wait_drained();
   endtask

   initial begin
      // The local registers start at their reset values. The tallies start cleared.
      cfg.bg_blue      = '0;
      cfg.bg_green     = '0;
      cfg.bg_red       = '0;
      cfg.dist_limit   = DIST_LIMIT_RESET;
      cfg.green_start  = GREEN_START_RESET;
      cfg.purple_start = PURPLE_START_RESET;
      cfg.purple_end   = PURPLE_END_RESET;
      red_hits = 0;
      green_hits = 0;
      purple_hits = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed cards use the reset registers: black background, limit 50 and
      // bands 30/90/150. The first card walks the special cases, which are:
      // a masked-out pixel, a pixel inside the background distance, a pixel exactly
      // at the limit and one just inside it, grey, pure red at hue zero, a hue that
      // rounds to 180 and wraps to zero, and the band boundaries 29/30, 89/90 and
      // 150/151. It ends with three hits in each band, and that tie goes to purple.
      push_pixel(8'd0,   8'd0,   8'd255, 1'b0, 1'b0);
      push_pixel(8'd10,  8'd10,  8'd10,  1'b1, 1'b0);
      push_pixel(8'd0,   8'd30,  8'd40,  1'b1, 1'b0);
      push_pixel(8'd0,   8'd30,  8'd39,  1'b1, 1'b0);
      push_pixel(8'd200, 8'd200, 8'd200, 1'b1, 1'b0);
      push_pixel(8'd0,   8'd0,   8'd255, 1'b1, 1'b0);
      push_pixel(8'd1,   8'd0,   8'd255, 1'b1, 1'b0);
      push_pixel(8'd246, 8'd0,   8'd255, 1'b1, 1'b0);
      push_pixel(8'd0,   8'd246, 8'd255, 1'b1, 1'b0);
      push_pixel(8'd0,   8'd255, 8'd255, 1'b1, 1'b0);
      push_pixel(8'd0,   8'd255, 8'd0,   1'b1, 1'b0);
      push_pixel(8'd246, 8'd255, 8'd0,   1'b1, 1'b0);
      push_pixel(8'd255, 8'd255, 8'd0,   1'b1, 1'b0);
      push_pixel(8'd255, 8'd0,   8'd0,   1'b1, 1'b0);
      push_pixel(8'd255, 8'd0,   8'd254, 1'b1, 1'b1);
      // This card is a single masked-out last pixel, so all counts are zero.
      push_pixel(8'd255, 8'd255, 8'd255, 1'b0, 1'b1);
      // Red ties with purple and beats green, so purple wins.
      push_pixel(8'd0,   8'd100, 8'd255, 1'b1, 1'b0);
      push_pixel(8'd0,   8'd50,  8'd255, 1'b1, 1'b0);
      push_pixel(8'd255, 8'd0,   8'd0,   1'b1, 1'b0);
      push_pixel(8'd255, 8'd0,   8'd0,   1'b1, 1'b1);
      // Clear red and clear green winners.
      push_pixel(8'd0,   8'd100, 8'd255, 1'b1, 1'b0);
      push_pixel(8'd0,   8'd100, 8'd255, 1'b1, 1'b1);
      push_pixel(8'd0,   8'd255, 8'd0,   1'b1, 1'b0);
      push_pixel(8'd0,   8'd255, 8'd0,   1'b1, 1'b1);
      wait_drained();

      // A write to the unused index must change nothing. The next phase checks this
      // with the reset registers still in place. In that phase the receiver holds
      // off for a long stretch while short cards keep coming. The result path fills
      // up and the block has to stall its input.
      write_reg(REG_UNUSED, '1);
      set_idling(IDLE_NONE);
      push_cards(60, 3);
      @(negedge clock);
      receiver_hold = 1'b1;
      repeat (HOLD_CYCLES) @(negedge clock);
      receiver_hold = 1'b0;
      wait_drained();

      run_phase(SET_RANDOM,     IDLE_SENDER,   240, 12, 1'b0);
      run_phase(SET_OPEN,       IDLE_RECEIVER, 200, 12, 1'b0);
      run_phase(SET_CLOSED,     IDLE_BOTH,      60,  6, 1'b0);
      run_phase(SET_REVERSED,   IDLE_NONE,     150, 12, 1'b0);
      run_phase(SET_NARROW,     IDLE_BOTH,     240, 12, 1'b1);
      run_phase(SET_WHITE_CARD, IDLE_SENDER,   240, 12, 1'b0);
      for (int i = 0; i < 4; i++) begin
         run_phase(SET_RANDOM, idle_type'(i), 180, 16, 1'b0);
      end

      if (verdicts_due.size() != 0) begin
         flag_error($sformatf("%0d card results never arrived", verdicts_due.size()));
      end
      $display("Run covered %0d pixels and %0d card results over %0d register settings,",
               pixels_sent, cards_checked, settings_used);
      $display("with idle and stall phases and a %0d-cycle receiver hold-off.",
               HOLD_CYCLES);
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
